>>> rtl/tolerance_palette_quantizer_unit_assert.svh
// ----------------------------------------------------------------------------
// Tolerance palette quantizer assertion macros
// Shared concurrent assertion forms, clocked on clk, reset on rst_n.
// ----------------------------------------------------------------------------
`ifndef TOLERANCE_PALETTE_QUANTIZER_UNIT_ASSERT_SVH
`define TOLERANCE_PALETTE_QUANTIZER_UNIT_ASSERT_SVH

// same-cycle implication
`define TPQ_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tpq assertion failed");

// next-cycle implication
`define TPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tpq assertion failed");

`endif

>>> rtl/tpq_pkg.sv
// ----------------------------------------------------------------------------
// tpq_pkg
// Types and constants of the tolerance palette quantizer.
// ----------------------------------------------------------------------------
package tpq_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int IDX_W         = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);
  localparam int CHAN_W        = 8;
  localparam int COLOR_IDX_W   = 8;
  localparam int ENTRIES_W     = 9;

  typedef struct packed {
    logic              frame_start;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } tpq_in_t;

  typedef struct packed {
    logic [COLOR_IDX_W-1:0] color_index;
    logic                   new_entry;
    logic                   overflow;
    logic [ENTRIES_W-1:0]   entries_used;
  } tpq_out_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } tpq_color_t;

  typedef struct packed {
    logic             valid;
    tpq_color_t       color;
    logic             found;
    logic             added;
    logic [IDX_W-1:0] index;
  } tpq_probe_t;

  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

>>> rtl/tpq_cell.sv
// ----------------------------------------------------------------------------
// tpq_cell
// One palette entry: compares the passing probe, inserts on the first free
// slot, and hands the probe to the next cell.
// ----------------------------------------------------------------------------
module tpq_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic [tpq_pkg::IDX_W-1:0]      cell_idx,
  input  logic [tpq_pkg::CNT_W-1:0]      count,
  input  logic [tpq_pkg::CHAN_W-1:0]     tol,
  input  tpq_pkg::tpq_probe_t            probe_in,
  output tpq_pkg::tpq_probe_t            probe_out
);

  tpq_pkg::tpq_color_t entry_r;
  tpq_pkg::tpq_probe_t probe_r;
  tpq_pkg::tpq_probe_t probe_nxt;
  logic [tpq_pkg::CNT_W-1:0] idx_ext;
  logic occupied;
  logic hit;
  logic take;
  logic ins;

  assign idx_ext  = tpq_pkg::CNT_W'(cell_idx);
  assign occupied = idx_ext < count;
  assign hit      = occupied &&
                    (tpq_pkg::abs_diff(entry_r.red,   probe_in.color.red)   <= tol) &&
                    (tpq_pkg::abs_diff(entry_r.green, probe_in.color.green) <= tol) &&
                    (tpq_pkg::abs_diff(entry_r.blue,  probe_in.color.blue)  <= tol);
  assign take     = probe_in.valid && !probe_in.found;
  assign ins      = take && !occupied && (idx_ext == count);

  always_comb begin
    probe_nxt = probe_in;
    if (take && hit) begin
      probe_nxt.found = 1'b1;
      probe_nxt.index = cell_idx;
    end else if (ins) begin
      probe_nxt.found = 1'b1;
      probe_nxt.added = 1'b1;
      probe_nxt.index = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r <= '0;
    end else if (adv) begin
      probe_r <= probe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ins) begin
      entry_r <= probe_in.color;
    end
  end

  assign probe_out = probe_r;

endmodule

>>> rtl/tpq_chain.sv
// ----------------------------------------------------------------------------
// tpq_chain
// Row of palette cells; a probe walks one cell per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module tpq_chain (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic [tpq_pkg::CNT_W-1:0]      count,
  input  logic [tpq_pkg::CHAN_W-1:0]     tol,
  input  tpq_pkg::tpq_probe_t            head,
  output tpq_pkg::tpq_probe_t            tail
);

  tpq_pkg::tpq_probe_t link [tpq_pkg::PALETTE_DEPTH+1];

  assign link[0] = head;

  for (genvar i = 0; i < tpq_pkg::PALETTE_DEPTH; i++) begin : g_cell
    tpq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .cell_idx  (tpq_pkg::IDX_W'(i)),
      .count     (count),
      .tol       (tol),
      .probe_in  (link[i]),
      .probe_out (link[i+1])
    );
  end

  assign tail = link[tpq_pkg::PALETTE_DEPTH];

endmodule

>>> rtl/tolerance_palette_quantizer_unit.sv
// A pixel is registered at launch, then walks the cell chain, and its result is
// registered at the output. One pixel at a time: the probe walks the whole cell
// chain, one cell per cycle while the output is not stalled, before the next
// pixel is taken. A stalled result stalls the chain. Reset is synchronous,
// active low: it empties the palette and sets tolerance to 0.
// ----------------------------------------------------------------------------
// tolerance_palette_quantizer_unit
// Maps each RGB pixel to a palette index, growing the palette per frame.
// ----------------------------------------------------------------------------
`include "tolerance_palette_quantizer_unit_assert.svh"

module tolerance_palette_quantizer_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tpq_pkg::tpq_in_t    in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tpq_pkg::tpq_out_t   out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);

  logic                          busy_r;
  logic [tpq_pkg::CNT_W-1:0]     count_r;
  logic [tpq_pkg::CNT_W-1:0]     count_nxt;
  logic [tpq_pkg::CHAN_W-1:0]    tol_r;
  tpq_pkg::tpq_probe_t           launch_r;
  tpq_pkg::tpq_probe_t           launch_nxt;
  tpq_pkg::tpq_probe_t           tail;
  tpq_pkg::tpq_out_t             out_r;
  tpq_pkg::tpq_out_t             out_nxt;
  logic                          out_valid_r;
  logic                          adv;
  logic                          in_fire;
  logic                          exit_fire;

  assign adv       = !(out_valid_r && !out_ready);
  assign in_ready  = !busy_r;
  assign in_fire   = in_valid && in_ready;
  assign exit_fire = tail.valid && adv;
  assign cfg_ready = 1'b1;

  always_comb begin
    launch_nxt             = '0;
    launch_nxt.valid       = 1'b1;
    launch_nxt.color.red   = in_data.red;
    launch_nxt.color.green = in_data.green;
    launch_nxt.color.blue  = in_data.blue;
  end

  always_comb begin
    count_nxt            = count_r + tpq_pkg::CNT_W'(tail.added);
    out_nxt.color_index  = tail.found ? tpq_pkg::COLOR_IDX_W'(tail.index) : '0;
    out_nxt.new_entry    = tail.added;
    out_nxt.overflow     = !tail.found;
    out_nxt.entries_used = tpq_pkg::ENTRIES_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      tol_r       <= '0;
      launch_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        tol_r <= cfg_data;
      end
      if (in_fire) begin
        busy_r   <= 1'b1;
        launch_r <= launch_nxt;
        if (in_data.frame_start) begin
          count_r <= '0;
        end
      end else if (adv) begin
        launch_r.valid <= 1'b0;
      end
      if (exit_fire) begin
        busy_r      <= 1'b0;
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exit_fire) begin
      out_r <= out_nxt;
    end
  end

  tpq_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .count (count_r),
    .tol   (tol_r),
    .head  (launch_r),
    .tail  (tail)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `TPQ_ASSERT_SAME(a_count_bound, 1'b1, count_r <= tpq_pkg::CNT_W'(tpq_pkg::PALETTE_DEPTH))
  `TPQ_ASSERT_SAME(a_tail_busy, tail.valid, busy_r)
  `TPQ_ASSERT_SAME(a_ovf_full, exit_fire && !tail.found, count_r == tpq_pkg::CNT_W'(tpq_pkg::PALETTE_DEPTH))
  `TPQ_ASSERT_NEXT(a_count_grow, exit_fire && tail.added, count_r == $past(count_r) + tpq_pkg::CNT_W'(1))

endmodule
